/* src/lrp_pkg.sv */
// Package for the layer refinement planner: item structs, memory entry
// layout, register indexes and sequencer states. No dependencies.
package lrp_pkg;

  typedef struct packed {
    logic               mode;
    logic [6:0]         layer_index;
    logic signed [15:0] probe_score;
    logic [15:0]        avg_entropy;
    logic [15:0]        unique_experts;
    logic [15:0]        total_expert_slots;
  } lrp_in_t;

  typedef struct packed {
    logic               refine_added;
    logic               flags_cleared;
    logic [6:0]         layer_out;
    logic signed [31:0] smoothed_score;
    logic [7:0]         pending_total;
  } lrp_out_t;

  // one layer entry of the state memory
  typedef struct packed {
    logic [3:0]         exec;
    logic [15:0]        ent;
    logic signed [31:0] ema;
  } lrp_entry_t;

  typedef enum logic [2:0] {
    REG_ALPHA   = 3'd0,
    REG_ENT_W   = 3'd1,
    REG_DIV_W   = 3'd2,
    REG_SIGMA   = 3'd3,
    REG_REVISIT = 3'd4,
    REG_PROTECT = 3'd5,
    REG_EPSILON = 3'd6,
    REG_LAYERS  = 3'd7
  } lrp_reg_t;

  localparam int unsigned MIN_STAT_LAYERS = 3;
  localparam logic [16:0] ALPHA_ONE       = 17'h10000;
  localparam logic [3:0]  EXEC_SAT        = 4'hF;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_LAT, S_MAX, S_DIVE, S_DIVD, S_FE, S_FD, S_FF, S_PL, S_PH,
    S_COMB, S_EMA1, S_EMA2, S_EMA3, S_EMAW, S_SUM, S_DIVM, S_DIVS, S_VAR,
    S_SQV, S_THR, S_SQN, S_DIVN, S_OUT
  } lrp_state_t;

endpackage

/* src/layer_refinement_planner_top.sv */
// Top level of the layer refinement planner: sequencer, state memory, one
// shared multiplier, a bit-serial divider and a digit-serial square root.
// Depends on lrp_pkg.

// A signal item makes two sweeps of the state memory (one entry a cycle, for
// the entropy maximum and then for count, sum and sum of squares), up to five
// passes of the divider at one quotient bit a cycle and up to two square roots.
// A clear item or a layer index at or beyond MAX_LAYERS skips all of these and
// goes straight to the output state. in_ready is high only between items; a
// finished result sits in the output register while the next item is taken.
module layer_refinement_planner_top
  import lrp_pkg::*;
#(
  parameter int MAX_LAYERS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  lrp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lrp_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);

  localparam int AW   = $clog2(MAX_LAYERS);
  localparam int CW   = $clog2(MAX_LAYERS + 1);
  localparam int IXW  = (AW > 7) ? AW : 7;
  localparam int LW   = IXW + 1;
  localparam int CNTW = AW + 2;
  localparam int SUMW = 32 + CW;
  localparam int SQW  = 63 + CW;
  localparam int DVW  = SQW;
  localparam int DCW  = $clog2(DVW + 1);

  // configuration
  logic [16:0]        alpha_r;
  logic [15:0]        ent_w_r, div_w_r, eps_r;
  logic signed [15:0] sigma_r;
  logic [3:0]         revisit_r;
  logic [6:0]         protect_r;
  logic [7:0]         layers_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= 17'd19661;
      ent_w_r   <= 16'd4096;
      div_w_r   <= 16'd4096;
      sigma_r   <= 16'sd4096;
      revisit_r <= 4'd2;
      protect_r <= 7'd2;
      eps_r     <= 16'd655;
      layers_r  <= 8'd32;
    end else if (cfg_we) begin
      unique case (lrp_reg_t'(cfg_index))
        REG_ALPHA:   alpha_r   <= cfg_wdata;
        REG_ENT_W:   ent_w_r   <= cfg_wdata[15:0];
        REG_DIV_W:   div_w_r   <= cfg_wdata[15:0];
        REG_SIGMA:   sigma_r   <= cfg_wdata[15:0];
        REG_REVISIT: revisit_r <= cfg_wdata[3:0];
        REG_PROTECT: protect_r <= cfg_wdata[6:0];
        REG_EPSILON: eps_r     <= cfg_wdata[15:0];
        REG_LAYERS:  layers_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  lrp_state_t state_r, state_nxt;
  lrp_in_t    in_r;
  lrp_out_t   out_data_r;
  logic       out_valid_r;

  logic [MAX_LAYERS-1:0] seen_r, pend_r;
  logic [7:0]            pend_cnt_r;
  logic [31:0]           prev_r;

  // datapath registers
  logic                  res_added_r, res_cleared_r;
  logic signed [31:0]    res_ema_r, ema_old_r, comp_r, mean_r;
  logic [3:0]            exec_new_r;
  logic [15:0]           maxe_r;
  logic [16:0]           ne_r, dv_r;
  logic [20:0]           fe_r, fd_r;
  logic [41:0]           pp_r;
  logic signed [59:0]    lo_r;
  logic signed [49:0]    t_r;
  logic [CNTW-1:0]       cnt_r;
  logic                  p1_v_r, p2_v_r;
  logic [AW-1:0]         p1_idx_r;
  logic [CW-1:0]         n_r;
  logic signed [SUMW-1:0] sum_r;
  logic [SQW-1:0]        sumsq_r;
  logic [63:0]           e_r;
  logic [31:0]           norm_r;

  // state memory
  lrp_entry_t mem [MAX_LAYERS];
  lrp_entry_t mem_rd_r, mem_wdata;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p_r;

  // divider
  logic           div_ld;
  logic [DVW-1:0] div_num, div_q_r;
  logic [31:0]    div_den, div_d_r, div_rem_r;
  logic [DCW-1:0] div_cnt_r;
  logic [32:0]    div_sh;
  logic           div_ge, div_done;

  // square root
  logic        sq_ld;
  logic [63:0] sq_in, sq_x_r;
  logic [34:0] sq_rem_r, sq_rem2, sq_trial;
  logic [31:0] sq_root_r;
  logic [5:0]  sq_cnt_r;
  logic        sq_ge, sq_done;

  // helpers
  logic [IXW-1:0]      li_ext;
  logic [AW-1:0]       idx;
  logic                in_range, issue, sweep_end, p1_seen;
  logic [15:0]         p1_ent;
  logic [16:0]         alpha_c;
  logic signed [59:0]  comp60, hi60;
  logic signed [35:0]  comp_s;
  logic signed [31:0]  comp_sat, ema3;
  logic signed [49:0]  ema_sum;
  logic [SUMW-1:0]     sum_mag;
  logic signed [SUMW-1:0] mean_w;
  logic [63:0]         msq, var_c;
  logic signed [39:0]  thr, ema40;
  logic signed [36:0]  sig_sh;
  logic signed [8:0]   upper_lim;
  logic                elig, flag_set, sq_hi;
  logic [31:0]         norm_c, diff;

  assign li_ext    = IXW'(in_r.layer_index);
  assign idx       = li_ext[AW-1:0];
  assign in_range  = LW'(in_data.layer_index) < LW'(MAX_LAYERS);
  assign issue     = cnt_r < CNTW'(MAX_LAYERS);
  assign sweep_end = cnt_r == CNTW'(MAX_LAYERS + 2);
  assign p1_seen   = seen_r[p1_idx_r];
  assign p1_ent    = (p1_idx_r == idx) ? in_r.avg_entropy :
                     (p1_seen ? mem_rd_r.ent : 16'd0);
  assign alpha_c   = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  always_comb begin
    hi60     = mul_p_r[59:0];
    comp60   = (hi60 <<< 21) + lo_r;
    comp_s   = comp60[59:24];
    if (comp_s > 36'sh0_7FFF_FFFF) comp_sat = 32'sh7FFF_FFFF;
    else if (comp_s < -36'sh0_8000_0000) comp_sat = -32'sh8000_0000;
    else comp_sat = comp_s[31:0];
    ema_sum  = t_r + mul_p_r[49:0];
    ema3     = ema_sum[47:16];
    sum_mag  = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
    mean_w   = SUMW'(div_q_r[SUMW-1:0]) + SUMW'(div_rem_r != 32'd0);
    msq      = mul_p_r[63:0];
    var_c    = (e_r > msq) ? e_r - msq : 64'd0;
    sig_sh   = mul_p_r[48:12];
    thr      = 40'(mean_r) + 40'(sig_sh);
    ema40    = 40'(res_ema_r);
    upper_lim = $signed({1'b0, layers_r}) - $signed({2'b00, protect_r});
    elig     = (exec_new_r <= revisit_r) && !pend_r[idx] &&
               (in_r.layer_index >= protect_r) &&
               ($signed({2'b00, in_r.layer_index}) < upper_lim);
    flag_set = (ema40 > thr) && elig;
    sq_hi    = sumsq_r[SQW-1:64] != '0;
    norm_c   = sq_hi ? 32'hFFFF_FFFF : sq_root_r;
    diff     = (norm_r > prev_r) ? norm_r - prev_r : prev_r - norm_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    div_ld    = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_ld     = 1'b0;
    sq_in     = '0;
    mul_a     = '0;
    mul_b     = '0;
    rd_addr   = idx;
    mem_we    = 1'b0;
    mem_wdata = '{exec: exec_new_r, ent: in_r.avg_entropy, ema: res_ema_r};
    in_ready  = state_r == S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.mode || !in_range) state_nxt = S_OUT;
          else state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_LAT;
      S_LAT: state_nxt = S_MAX;
      S_MAX: begin
        rd_addr = cnt_r[AW-1:0];
        if (sweep_end) begin
          div_ld    = 1'b1;
          div_num   = DVW'({in_r.avg_entropy, 16'h0000});
          div_den   = 32'(maxe_r);
          state_nxt = S_DIVE;
        end
      end
      S_DIVE: begin
        if (div_done) begin
          div_ld    = 1'b1;
          div_num   = DVW'({in_r.unique_experts, 16'h0000});
          div_den   = 32'(in_r.total_expert_slots);
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        mul_a = 33'(ent_w_r);
        mul_b = 33'(ne_r);
        if (div_done) state_nxt = S_FE;
      end
      S_FE: begin
        mul_a     = 33'(div_w_r);
        mul_b     = 33'(dv_r);
        state_nxt = S_FD;
      end
      S_FD: state_nxt = S_FF;
      S_FF: begin
        mul_a     = 33'(fe_r);
        mul_b     = 33'(fd_r);
        state_nxt = S_PL;
      end
      S_PL: begin
        mul_a     = 33'(in_r.probe_score);
        mul_b     = 33'(mul_p_r[20:0]);
        state_nxt = S_PH;
      end
      S_PH: begin
        mul_a     = 33'(in_r.probe_score);
        mul_b     = 33'(pp_r[41:21]);
        state_nxt = S_COMB;
      end
      S_COMB: state_nxt = S_EMA1;
      S_EMA1: begin
        mul_a     = 33'(alpha_c);
        mul_b     = 33'(comp_r);
        state_nxt = seen_r[idx] ? S_EMA2 : S_EMAW;
      end
      S_EMA2: begin
        mul_a     = 33'(ALPHA_ONE - alpha_c);
        mul_b     = 33'(ema_old_r);
        state_nxt = S_EMA3;
      end
      S_EMA3: state_nxt = S_EMAW;
      S_EMAW: begin
        mem_we    = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        rd_addr = cnt_r[AW-1:0];
        mul_a   = 33'(mem_rd_r.ema);
        mul_b   = 33'(mem_rd_r.ema);
        if (sweep_end) begin
          if (n_r < CW'(MIN_STAT_LAYERS)) begin
            state_nxt = S_OUT;
          end else begin
            div_ld    = 1'b1;
            div_num   = DVW'(sum_mag);
            div_den   = 32'(n_r);
            state_nxt = S_DIVM;
          end
        end
      end
      S_DIVM: begin
        if (div_done) begin
          div_ld    = 1'b1;
          div_num   = DVW'(sumsq_r);
          div_den   = 32'(n_r);
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        mul_a = 33'(mean_r);
        mul_b = 33'(mean_r);
        if (div_done) state_nxt = S_VAR;
      end
      S_VAR: begin
        sq_ld     = 1'b1;
        sq_in     = var_c;
        state_nxt = S_SQV;
      end
      S_SQV: begin
        mul_a = 33'(sigma_r);
        mul_b = 33'(sq_root_r);
        if (sq_done) state_nxt = S_THR;
      end
      S_THR: begin
        sq_ld     = 1'b1;
        sq_in     = sumsq_r[63:0];
        state_nxt = S_SQN;
      end
      S_SQN: begin
        if (sq_done) begin
          if (prev_r != 32'd0 && norm_c != 32'd0) begin
            state_nxt = S_DIVN;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIVN: begin
        // first cycle loads, the rest iterate
        if (div_cnt_r == '0 && !p2_v_r) begin
          div_ld  = 1'b1;
          div_num = DVW'({diff, 16'h0000});
          div_den = prev_r;
        end else if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx] <= mem_wdata;
    mem_rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // divider: one quotient bit a cycle
  assign div_sh   = {div_rem_r, div_q_r[DVW-1]};
  assign div_ge   = div_sh >= {1'b0, div_d_r};
  assign div_done = div_cnt_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_ld) begin
      div_q_r   <= div_num;
      div_rem_r <= '0;
      div_d_r   <= div_den;
      div_cnt_r <= DCW'(DVW);
    end else if (!div_done) begin
      div_q_r   <= {div_q_r[DVW-2:0], div_ge};
      div_rem_r <= div_ge ? 32'(div_sh - {1'b0, div_d_r}) : div_sh[31:0];
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // square root: two radicand bits a cycle
  assign sq_rem2  = {sq_rem_r[32:0], sq_x_r[63:62]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign sq_ge    = sq_rem2 >= sq_trial;
  assign sq_done  = sq_cnt_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (sq_ld) begin
      sq_x_r    <= sq_in;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= 6'd32;
    end else if (!sq_done) begin
      sq_x_r    <= {sq_x_r[61:0], 2'b00};
      sq_rem_r  <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
      sq_root_r <= {sq_root_r[30:0], sq_ge};
      sq_cnt_r  <= sq_cnt_r - 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        in_r          <= in_data;
        res_added_r   <= 1'b0;
        res_cleared_r <= in_data.mode;
        res_ema_r     <= '0;
      end
      S_LAT: begin
        ema_old_r  <= mem_rd_r.ema;
        if (!seen_r[idx]) exec_new_r <= 4'd1;
        else if (mem_rd_r.exec != EXEC_SAT) exec_new_r <= mem_rd_r.exec + 4'd1;
        else exec_new_r <= EXEC_SAT;
        maxe_r <= '0;
        cnt_r  <= '0;
        p1_v_r <= 1'b0;
      end
      S_MAX: begin
        cnt_r    <= cnt_r + 1'b1;
        p1_v_r   <= issue;
        p1_idx_r <= cnt_r[AW-1:0];
        if (p1_v_r && p1_ent > maxe_r) maxe_r <= p1_ent;
      end
      S_DIVE: begin
        if (div_done) ne_r <= (maxe_r == 16'd0) ? 17'd0 : div_q_r[16:0];
      end
      S_DIVD: begin
        if (div_done) begin
          if (in_r.total_expert_slots == 16'd0) dv_r <= 17'd0;
          else if (div_q_r > DVW'(ALPHA_ONE)) dv_r <= ALPHA_ONE;
          else dv_r <= div_q_r[16:0];
        end
      end
      S_FE:   fe_r <= 21'(ALPHA_ONE) + mul_p_r[32:12];
      S_FD:   fd_r <= 21'(ALPHA_ONE) + mul_p_r[32:12];
      S_PL:   pp_r <= mul_p_r[41:0];
      S_PH:   lo_r <= mul_p_r[59:0];
      S_COMB: comp_r <= comp_sat;
      S_EMA1: if (!seen_r[idx]) res_ema_r <= comp_r;
      S_EMA2: t_r <= mul_p_r[49:0];
      S_EMA3: res_ema_r <= ema3;
      S_EMAW: begin
        cnt_r   <= '0;
        p1_v_r  <= 1'b0;
        p2_v_r  <= 1'b0;
        n_r     <= '0;
        sum_r   <= '0;
        sumsq_r <= '0;
      end
      S_SUM: begin
        cnt_r    <= cnt_r + 1'b1;
        p1_v_r   <= issue;
        p1_idx_r <= cnt_r[AW-1:0];
        p2_v_r   <= p1_v_r && p1_seen;
        if (p1_v_r && p1_seen) begin
          n_r   <= n_r + 1'b1;
          sum_r <= sum_r + SUMW'(mem_rd_r.ema);
        end
        if (p2_v_r) sumsq_r <= sumsq_r + SQW'(mul_p_r[63:0]);
      end
      S_DIVM: begin
        if (div_done) begin
          if (sum_r[SUMW-1]) mean_r <= 32'(-mean_w);
          else mean_r <= 32'(div_q_r[SUMW-1:0]);
        end
      end
      S_DIVS: if (div_done) e_r <= div_q_r[63:0];
      S_THR:  if (flag_set) res_added_r <= 1'b1;
      S_SQN: begin
        norm_r <= norm_c;
        p2_v_r <= 1'b0;
      end
      S_DIVN: begin
        // marks that the divide was launched
        p2_v_r <= 1'b1;
        if (p2_v_r && div_done && div_q_r < DVW'(eps_r)) begin
          res_added_r   <= 1'b0;
          res_cleared_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      pend_r      <= '0;
      pend_cnt_r  <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_data.mode) begin
            pend_r     <= '0;
            pend_cnt_r <= '0;
          end
        end
        S_EMAW: seen_r[idx] <= 1'b1;
        S_THR: begin
          if (flag_set) begin
            pend_r[idx] <= 1'b1;
            pend_cnt_r  <= pend_cnt_r + 8'd1;
          end
        end
        S_SQN: begin
          if (sq_done && !(prev_r != 32'd0 && norm_c != 32'd0)) prev_r <= norm_c;
        end
        S_DIVN: begin
          if (p2_v_r && div_done) begin
            prev_r <= norm_r;
            if (div_q_r < DVW'(eps_r)) begin
              pend_r     <= '0;
              pend_cnt_r <= '0;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_data_r <= '{refine_added: res_added_r, flags_cleared: res_cleared_r,
                      layer_out: in_r.layer_index, smoothed_score: res_ema_r,
                      pending_total: pend_cnt_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/lrp_checker.sv */
// Port-level checks for the layer refinement planner, bound to its top level.
// Depends on lrp_pkg.
module lrp_checker
  import lrp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input lrp_out_t out_data
);

  // one item at a time: ready drops after each accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is at work");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.flags_cleared |-> out_data.pending_total == 8'd0)
    else $error("flags cleared but pending count nonzero");

  a_added_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.refine_added |->
      out_data.pending_total != 8'd0 && !out_data.flags_cleared)
    else $error("added flag not reflected in pending count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

endmodule

bind layer_refinement_planner_top lrp_checker u_lrp_checker (.*);
